@@ design/lca_pkg.sv @@
package lca_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SIZE_W   = 7;
  localparam int MASK_W   = 9;
  localparam int CFG_W    = 9;
  localparam int CIDX_W   = 2;
  localparam int CNT_W    = 4;

  localparam logic [SIZE_W-1:0] MAX_COLS_V = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] MAX_ROWS_V = SIZE_W'(MAX_ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(MAX_ROWS - 1);

  localparam logic [SIZE_W-1:0] COLS_RESET    = 7'd50;
  localparam logic [SIZE_W-1:0] ROWS_RESET    = 7'd50;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'b000001100;
  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'b000001000;

  localparam logic [CIDX_W-1:0] CFG_COLS    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SURVIVE = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_BIRTH   = 2'd3;

  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_TOGGLE  = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_ADVANCE = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] col_index;
    logic [5:0] row_index;
    logic       write_value;
  } in_word_t;

  typedef struct packed {
    logic cell_value;
    logic out_of_range;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MODIFY,
    ST_ADV_FIRST,
    ST_ADV_FILL,
    ST_ADV_ROW,
    ST_DONE
  } lca_state_t;

  typedef struct packed {
    logic load_item;
    logic clear_grid;
    logic acc_modify;
    logic adv_first;
    logic adv_fill;
    logic adv_row;
    logic out_load;
  } lca_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       in_grid;
    logic       row_last;
    logic       out_busy;
  } lca_stat_t;

endpackage

@@ design/lca_ram.sv @@
module lca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/lca_ctrl.sv @@
module lca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lca_pkg::lca_stat_t stat,
  output lca_pkg::lca_cmd_t  cmd
);
  import lca_pkg::*;

  lca_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.kind)
          KIND_WRITE, KIND_TOGGLE, KIND_READ:
            state_next = stat.in_grid ? ST_MODIFY : ST_DONE;
          KIND_ADVANCE: state_next = ST_ADV_FIRST;
          default:      state_next = ST_DONE;
        endcase
      end
      ST_MODIFY:    state_next = ST_DONE;
      ST_ADV_FIRST: state_next = ST_ADV_FILL;
      ST_ADV_FILL:  state_next = ST_ADV_ROW;
      ST_ADV_ROW: begin
        if (stat.row_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_DISPATCH:  cmd.clear_grid = (stat.kind == KIND_CLEAR);
      ST_MODIFY:    cmd.acc_modify = 1'b1;
      ST_ADV_FIRST: cmd.adv_first  = 1'b1;
      ST_ADV_FILL:  cmd.adv_fill   = 1'b1;
      ST_ADV_ROW:   cmd.adv_row    = 1'b1;
      ST_DONE:      cmd.out_load   = !stat.out_busy;
      default:      cmd = '0;
    endcase
  end

endmodule

@@ design/lca_datapath.sv @@
module lca_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lca_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [lca_pkg::CFG_W-1:0]        cfg_data,
  input  lca_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lca_pkg::out_word_t               out_word,
  input  lca_pkg::lca_cmd_t                cmd,
  output lca_pkg::lca_stat_t               stat
);
  import lca_pkg::*;

  logic [SIZE_W-1:0]   cols_cfg, rows_cfg;
  logic [MASK_W-1:0]   survive_cfg, birth_cfg;
  logic [SIZE_W-1:0]   eff_cols, eff_rows;
  logic [MAX_COLS-1:0] col_mask;
  logic                in_grid;

  in_word_t            item;
  logic                res_value;
  logic [ROW_W-1:0]    sweep_row;
  logic [MAX_COLS-1:0] above, cur;
  logic [MAX_ROWS-1:0] row_valid;
  logic                rd_valid;

  logic [ROW_W-1:0]    rd_addr, wr_addr;
  logic [MAX_COLS-1:0] ram_rd_data, rd_word, wr_data, below, next_gen, mod_row;
  logic                wr_en, old_bit, acc_write;
  logic [MAX_COLS+1:0] pad_above, pad_cur, pad_below;
  logic [CNT_W-1:0]    cnt;
  logic [15:0]         survive_ext, birth_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg    <= COLS_RESET;
      rows_cfg    <= ROWS_RESET;
      survive_cfg <= SURVIVE_RESET;
      birth_cfg   <= BIRTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLS:    cols_cfg    <= cfg_data[SIZE_W-1:0];
        CFG_ROWS:    rows_cfg    <= cfg_data[SIZE_W-1:0];
        CFG_SURVIVE: survive_cfg <= cfg_data[MASK_W-1:0];
        CFG_BIRTH:   birth_cfg   <= cfg_data[MASK_W-1:0];
        default:     cols_cfg    <= cols_cfg;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg == '0) begin
      eff_cols = SIZE_W'(1);
    end else if (cols_cfg > MAX_COLS_V) begin
      eff_cols = MAX_COLS_V;
    end else begin
      eff_cols = cols_cfg;
    end
    if (rows_cfg == '0) begin
      eff_rows = SIZE_W'(1);
    end else if (rows_cfg > MAX_ROWS_V) begin
      eff_rows = MAX_ROWS_V;
    end else begin
      eff_rows = rows_cfg;
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (SIZE_W'(c) < eff_cols);
    end
  end

  assign in_grid = ({1'b0, item.col_index} < eff_cols) && ({1'b0, item.row_index} < eff_rows);

  assign stat.kind     = item.kind;
  assign stat.in_grid  = in_grid;
  assign stat.row_last = (sweep_row == ROW_LAST);
  assign stat.out_busy = out_valid && out_stall;

  // row store, rows never written since reset or clear read as dead
  always_comb begin
    if (cmd.adv_first) begin
      rd_addr = '0;
    end else if (cmd.adv_fill) begin
      rd_addr = ROW_W'(1);
    end else if (cmd.adv_row) begin
      rd_addr = sweep_row + ROW_W'(2);
    end else begin
      rd_addr = item.row_index[ROW_W-1:0];
    end
  end

  lca_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_word = rd_valid ? ram_rd_data : '0;

  always_ff @(posedge clk) begin
    rd_valid <= row_valid[rd_addr];
    if (rst || cmd.clear_grid) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // single cell access
  always_comb begin
    old_bit   = rd_word[item.col_index];
    mod_row   = rd_word;
    acc_write = 1'b0;
    case (item.kind)
      KIND_WRITE: begin
        mod_row[item.col_index] = item.write_value;
        acc_write               = 1'b1;
      end
      KIND_TOGGLE: begin
        mod_row[item.col_index] = ~old_bit;
        acc_write               = 1'b1;
      end
      default: acc_write = 1'b0;
    endcase
  end

  // neighbour count for one row of the sweep
  assign below = ({1'b0, sweep_row} + SIZE_W'(1) < eff_rows) ? (rd_word & col_mask) : '0;
  assign pad_above   = {1'b0, above, 1'b0};
  assign pad_cur     = {1'b0, cur, 1'b0};
  assign pad_below   = {1'b0, below, 1'b0};
  assign survive_ext = {7'b0, survive_cfg};
  assign birth_ext   = {7'b0, birth_cfg};

  always_comb begin
    next_gen = '0;
    cnt      = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = CNT_W'(pad_above[c]) + CNT_W'(pad_above[c+1]) + CNT_W'(pad_above[c+2])
          + CNT_W'(pad_cur[c]) + CNT_W'(pad_cur[c+2])
          + CNT_W'(pad_below[c]) + CNT_W'(pad_below[c+1]) + CNT_W'(pad_below[c+2]);
      next_gen[c] = cur[c] ? survive_ext[cnt] : birth_ext[cnt];
    end
  end

  always_comb begin
    if (cmd.adv_row) begin
      wr_en   = 1'b1;
      wr_addr = sweep_row;
      wr_data = ({1'b0, sweep_row} < eff_rows) ? (next_gen & col_mask) : '0;
    end else begin
      wr_en   = cmd.acc_modify && acc_write;
      wr_addr = item.row_index[ROW_W-1:0];
      wr_data = mod_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item      <= in_word;
      res_value <= 1'b0;
    end
    if (cmd.acc_modify) begin
      case (item.kind)
        KIND_TOGGLE: res_value <= ~old_bit;
        KIND_READ:   res_value <= old_bit;
        default:     res_value <= 1'b0;
      endcase
    end
    if (cmd.adv_fill) begin
      above     <= '0;
      cur       <= rd_word & col_mask;
      sweep_row <= '0;
    end else if (cmd.adv_row) begin
      above     <= cur;
      cur       <= below;
      sweep_row <= sweep_row + ROW_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_word.cell_value   <= res_value;
      out_word.out_of_range <= !in_grid && (item.kind == KIND_WRITE
                               || item.kind == KIND_TOGGLE || item.kind == KIND_READ);
    end
  end

endmodule

@@ design/life_like_cellular_automaton.sv @@
// life-like cellular automaton on a bounded 64 x 64 grid of one-bit cells
//
// input channel in_valid / in_stall / in_word: one word is one command
// (write, toggle or read a cell, clear the grid, advance one generation).
// output channel out_valid / out_stall / out_word: exactly one result word per
// command, in order: cell value after toggle or read, and an out-of-range flag.
// configuration: cfg_wr_en, cfg_index, cfg_data write column count, row count,
// survive mask and birth mask; write only while the block is idle.
// one command is in flight at a time. a generation is a sweep over the row memory
// at one row per cycle, after a line-buffer fill in the ADV_FIRST and ADV_FILL
// states. the next word is taken the cycle after the result is loaded into the
// output register.
// reset clears all cells (per-row valid flags, no clearing pass) and loads the
// default B3/S23 rule with a 50 x 50 grid.
// while the receiver stalls, the result holds in the output register and the
// block can still take the next command, but it waits before delivering that
// command's result until the register is free.
module life_like_cellular_automaton (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lca_pkg::CIDX_W-1:0] cfg_index,
  input  logic [lca_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lca_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lca_pkg::out_word_t         out_word
);
  import lca_pkg::*;

  lca_cmd_t  cmd;
  lca_stat_t stat;

  lca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lca_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ design/lca_checker.sv @@
module lca_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input lca_pkg::out_word_t         out_word
);
  import lca_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in flight");

  a_oor_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_of_range |-> !out_word.cell_value)
    else $error("out-of-range result carries a cell value");

endmodule

bind life_like_cellular_automaton lca_checker u_lca_checker (.*);
